// ===== rtl/core/go_back_n_sender_window_macros.svh =====
// Assertion helpers used by the datapath.
`ifndef GO_BACK_N_SENDER_WINDOW_MACROS_SVH
`define GO_BACK_N_SENDER_WINDOW_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBNSW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBNSW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/gbnsw_pkg.sv =====
`default_nettype none

package gbnsw_pkg;

    localparam int SEQ_W       = 16;
    localparam int RETRY_W     = 8;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int WINDOW_DEF  = 8;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] ACT_ACK     = 2'd0;
    localparam logic [1:0] ACT_TIMEOUT = 2'd1;
    localparam logic [1:0] ACT_START   = 2'd2;
    localparam logic [1:0] ACT_NONE    = 2'd3;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_PROBE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ABORT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_SEQ   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'd1;

    typedef struct packed {
        logic [1:0]       action;
        logic [SEQ_W-1:0] ack_seq;
        logic [SEQ_W-1:0] peer_window;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SEQ_W-1:0] seq;
        logic             last;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic step_new;
        logic step_old;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic slot_free;
        logic go_new;
        logic go_old;
        logic cond_new;
        logic cont_new;
        logic cond_old;
        logic cont_old;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/core/gbnsw_chan_if.sv =====
`default_nettype none

interface gbnsw_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gbnsw_ctrl.sv =====
`default_nettype none

module gbnsw_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire gbnsw_pkg::t_sts i_sts,
    output gbnsw_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_NEW  = 2'd1;
    localparam logic [1:0] S_OLD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        o_in_ready      = (r_state == S_IDLE) && i_sts.slot_free;
        o_cmd.accept    = i_in_valid && o_in_ready;
        o_cmd.step_new  = (r_state == S_NEW) && i_sts.slot_free;
        o_cmd.step_old  = (r_state == S_OLD) && i_sts.slot_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.accept && i_sts.go_new) begin
                    n_state = S_NEW;
                end else if (o_cmd.accept && i_sts.go_old) begin
                    n_state = S_OLD;
                end
            end
            S_NEW: begin
                if (o_cmd.step_new && (!i_sts.cond_new || !i_sts.cont_new)) begin
                    n_state = S_IDLE;
                end
            end
            S_OLD: begin
                if (o_cmd.step_old && (!i_sts.cond_old || !i_sts.cont_old)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/gbnsw_datapath.sv =====
`default_nettype none

module gbnsw_datapath #(
    parameter int WINDOW = gbnsw_pkg::WINDOW_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [gbnsw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [gbnsw_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire gbnsw_pkg::t_in_item                i_evt,
    input  wire gbnsw_pkg::t_cmd                    i_cmd,
    output gbnsw_pkg::t_sts                         o_sts,
    output gbnsw_pkg::t_out_item                    o_item,
    output logic                                    o_item_valid,
    input  wire logic                               i_item_ready
);

    `include "go_back_n_sender_window_macros.svh"

    localparam int SW = gbnsw_pkg::SEQ_W;
    localparam int RW = gbnsw_pkg::RETRY_W;
    localparam int CW = gbnsw_pkg::CNT_W;
    localparam logic [SW-1:0] WIN_LIM     = SW'(WINDOW);
    localparam logic [CW-1:0] MAX_CNT     = CW'(gbnsw_pkg::MAX_RESULTS);
    localparam logic [RW-1:0] RETRY_SAT   = {RW{1'b1}};

    // Configuration registers.
    logic [SW-1:0] r_final_seq;
    logic [RW-1:0] r_retry_limit;

    // Sender state.
    logic [SW-1:0] r_base,      n_base;
    logic [SW-1:0] r_next,      n_next;
    logic [SW-1:0] r_plimit,    n_plimit;
    logic [RW-1:0] r_retry,     n_retry;
    logic          r_probing,   n_probing;
    logic          r_final_sent, n_final_sent;
    logic          r_finished,  n_finished;

    // Loop registers: result count and resend pointer.
    logic [CW-1:0] r_cnt,       n_cnt;
    logic [SW:0]   r_ptr,       n_ptr;

    // Output register.
    gbnsw_pkg::t_out_item r_item, n_item;
    logic                 r_item_valid, n_item_valid;
    logic                 load;

    logic [SW-1:0] win;
    logic [SW:0]   win_end;
    logic [SW:0]   top;
    logic          cnt_full;
    logic [CW-1:0] cnt_inc;
    logic          cnt_inc_full;
    logic          fs_after;
    logic [SW-1:0] next_after;
    logic [SW:0]   ptr_inc;

    logic          live;
    logic          ack_done;
    logic [RW-1:0] retry_inc;
    logic          abort;
    logic [SW:0]   ack_plus;

    always_comb begin
        win          = (r_plimit < WIN_LIM) ? r_plimit : WIN_LIM;
        win_end      = {1'b0, r_base} + {1'b0, win};
        top          = r_final_sent ? ({1'b0, r_next} + (SW+1)'(1)) : {1'b0, r_next};
        cnt_full     = r_cnt >= MAX_CNT;
        cnt_inc      = r_cnt + CW'(1);
        cnt_inc_full = cnt_inc >= MAX_CNT;
        fs_after     = r_next >= r_final_seq;
        next_after   = fs_after ? r_next : (r_next + SW'(1));
        ptr_inc      = r_ptr + (SW+1)'(1);

        o_sts.slot_free = !r_item_valid || i_item_ready;
        o_sts.cond_new  = !r_final_sent && !cnt_full && ({1'b0, r_next} < win_end);
        o_sts.cont_new  = !fs_after && !cnt_inc_full && ({1'b0, next_after} < win_end);
        o_sts.cond_old  = (r_ptr < top) && (SW'(r_cnt) < win) && !cnt_full;
        o_sts.cont_old  = (ptr_inc < top) && (SW'(cnt_inc) < win) && !cnt_inc_full;

        live      = !r_finished && (i_evt.action != gbnsw_pkg::ACT_NONE);
        ack_done  = r_final_sent && (i_evt.ack_seq >= r_next);
        retry_inc = (r_retry != RETRY_SAT) ? (r_retry + RW'(1)) : r_retry;
        abort     = retry_inc >= r_retry_limit;
        ack_plus  = {1'b0, i_evt.ack_seq} + (SW+1)'(1);

        o_sts.go_new = live && ((i_evt.action == gbnsw_pkg::ACT_START) ||
                       ((i_evt.action == gbnsw_pkg::ACT_ACK) && !ack_done &&
                        (i_evt.peer_window != '0)));
        o_sts.go_old = live && (i_evt.action == gbnsw_pkg::ACT_TIMEOUT) &&
                       !abort && !r_probing;
    end

    always_comb begin
        n_base       = r_base;
        n_next       = r_next;
        n_plimit     = r_plimit;
        n_retry      = r_retry;
        n_probing    = r_probing;
        n_final_sent = r_final_sent;
        n_finished   = r_finished;
        n_cnt        = r_cnt;
        n_ptr        = r_ptr;
        n_item       = r_item;
        load         = 1'b0;

        if (i_cmd.accept) begin
            n_cnt = '0;
            n_ptr = {1'b0, r_base};
            if (live) begin
                unique case (i_evt.action)
                    gbnsw_pkg::ACT_START: begin
                        n_retry = '0;
                    end
                    gbnsw_pkg::ACT_ACK: begin
                        n_retry = '0;
                        if (ack_done) begin
                            n_finished = 1'b1;
                            n_probing  = 1'b0;
                            n_base     = r_next;
                            load       = 1'b1;
                            n_item     = '{kind: gbnsw_pkg::KIND_DONE, seq: '0, last: 1'b1};
                        end else if (i_evt.peer_window == '0) begin
                            n_probing = 1'b1;
                            load      = 1'b1;
                            n_item    = '{kind: gbnsw_pkg::KIND_PROBE, seq: '0, last: 1'b1};
                        end else begin
                            n_probing = 1'b0;
                            n_plimit  = i_evt.peer_window;
                            if (i_evt.ack_seq >= r_base) begin
                                n_base = (ack_plus < {1'b0, r_next}) ? ack_plus[SW-1:0]
                                                                      : r_next;
                            end
                        end
                    end
                    gbnsw_pkg::ACT_TIMEOUT: begin
                        n_retry = retry_inc;
                        if (abort) begin
                            n_finished = 1'b1;
                            load       = 1'b1;
                            n_item     = '{kind: gbnsw_pkg::KIND_ABORT, seq: '0, last: 1'b1};
                        end else if (r_probing) begin
                            load   = 1'b1;
                            n_item = '{kind: gbnsw_pkg::KIND_PROBE, seq: '0, last: 1'b1};
                        end
                    end
                    default: begin
                        n_retry = r_retry;
                    end
                endcase
            end
        end else if (i_cmd.step_new && o_sts.cond_new) begin
            load         = 1'b1;
            n_item       = '{kind: gbnsw_pkg::KIND_DATA, seq: r_next,
                             last: !o_sts.cont_new};
            n_final_sent = fs_after;
            n_next       = next_after;
            n_cnt        = cnt_inc;
        end else if (i_cmd.step_old && o_sts.cond_old) begin
            load   = 1'b1;
            n_item = '{kind: gbnsw_pkg::KIND_DATA, seq: r_ptr[SW-1:0],
                       last: !o_sts.cont_old};
            n_ptr  = ptr_inc;
            n_cnt  = cnt_inc;
        end

        n_item_valid = load ? 1'b1 : (i_item_ready ? 1'b0 : r_item_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_final_seq   <= SW'(1);
            r_retry_limit <= RW'(5);
            r_base        <= SW'(1);
            r_next        <= SW'(1);
            r_plimit      <= WIN_LIM;
            r_retry       <= '0;
            r_probing     <= 1'b0;
            r_final_sent  <= 1'b0;
            r_finished    <= 1'b0;
            r_cnt         <= '0;
            r_item_valid  <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == gbnsw_pkg::CFG_FINAL_SEQ)) begin
                r_final_seq <= i_cfg_data[SW-1:0];
            end
            if (i_cfg_we && (i_cfg_idx == gbnsw_pkg::CFG_RETRY_LIMIT)) begin
                r_retry_limit <= i_cfg_data[RW-1:0];
            end
            r_base       <= n_base;
            r_next       <= n_next;
            r_plimit     <= n_plimit;
            r_retry      <= n_retry;
            r_probing    <= n_probing;
            r_final_sent <= n_final_sent;
            r_finished   <= n_finished;
            r_cnt        <= n_cnt;
            r_item_valid <= n_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_item <= n_item;
    end

    assign o_item       = r_item;
    assign o_item_valid = r_item_valid;

    `GBNSW_ASSERT_NEXT(a_finished_sticks, r_finished, r_finished, "finished flag dropped")
    `GBNSW_ASSERT_NEXT(a_final_holds_next, r_final_sent, $stable(r_next), "next_seq moved after final")
    `GBNSW_ASSERT_SAME(a_base_le_next, 1'b1, r_base <= r_next, "window base passed next_seq")
    `GBNSW_ASSERT_SAME(a_cnt_bound, 1'b1, r_cnt <= MAX_CNT, "result count overran")

endmodule

`default_nettype wire

// ===== rtl/core/go_back_n_sender_window.sv =====
`default_nettype none

// Go-Back-N sender window control. Each event transfer (acknowledgement,
// timeout or start) is turned into a burst of commands, possibly none, on the
// result channel: data sends, a window probe, done or abort, with last set on
// the final one of the burst. An event that sends data packets (up to 8, one
// per cycle from the send loop in the datapath while the result channel does
// not stall) keeps the block busy until the loop ends. The next event is taken
// only once the output register is empty or its result is transferred in that
// same cycle. After done or abort all events are ignored until reset.
module go_back_n_sender_window #(
    parameter int WINDOW = gbnsw_pkg::WINDOW_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [gbnsw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [gbnsw_pkg::CFG_W-1:0]     i_cfg_data,
    gbnsw_chan_if.sink                           i_evt,
    gbnsw_chan_if.source                         o_res
);

    gbnsw_pkg::t_cmd cmd;
    gbnsw_pkg::t_sts sts;

    gbnsw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_evt.valid),
        .o_in_ready (i_evt.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gbnsw_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_evt        (i_evt.data),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_item       (o_res.data),
        .o_item_valid (o_res.valid),
        .i_item_ready (o_res.ready)
    );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int SEQ_W         = gbnsw_pkg::SEQ_W;
    localparam int RETRY_W       = gbnsw_pkg::RETRY_W;
    localparam int CFG_W         = gbnsw_pkg::CFG_W;
    localparam int CFG_IDX_W     = gbnsw_pkg::CFG_IDX_W;
    localparam int MAX_RESULTS   = gbnsw_pkg::MAX_RESULTS;
    localparam int WIN           = gbnsw_pkg::WINDOW_DEF;
    localparam int SETTLE_CYCLES = 24;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    gbnsw_chan_if #(.t_payload(gbnsw_pkg::t_in_item))  evt_ch ();
    gbnsw_chan_if #(.t_payload(gbnsw_pkg::t_out_item)) res_ch ();

    go_back_n_sender_window i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_evt      (evt_ch),
        .o_res      (res_ch)
    );

    // Sender-side window state as the block should hold it.
    logic [SEQ_W-1:0]   final_seq_r;
    logic [RETRY_W-1:0] retry_limit_r;
    logic [SEQ_W-1:0]   base_q;
    logic [SEQ_W-1:0]   next_q;
    logic [SEQ_W-1:0]   peer_q;
    logic [RETRY_W-1:0] retries_q;
    bit                 probing_q;
    bit                 final_sent_q;
    bit                 finished_q;

    gbnsw_pkg::t_out_item cmd_buf [MAX_RESULTS];
    int                   n_cmd;
    gbnsw_pkg::t_out_item pending_cmds [$];

    int errors;
    bit src_jitter;
    bit sink_jitter;
    int sink_wait;
    int hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int usable_window();
        return (peer_q < WIN) ? int'(peer_q) : WIN;
    endfunction

    function automatic void add_cmd(input logic [1:0] kind,
                                    input logic [SEQ_W-1:0] seq);
        if (n_cmd >= MAX_RESULTS)
            return;
        cmd_buf[n_cmd].kind = kind;
        cmd_buf[n_cmd].seq  = seq;
        cmd_buf[n_cmd].last = 1'b0;
        n_cmd++;
    endfunction

    function automatic void send_fresh();
        logic [SEQ_W:0] lim;
        lim = {1'b0, base_q} + (SEQ_W+1)'(usable_window());
        while (!final_sent_q && n_cmd < MAX_RESULTS && {1'b0, next_q} < lim) begin
            add_cmd(gbnsw_pkg::KIND_DATA, next_q);
            if (next_q >= final_seq_r)
                final_sent_q = 1'b1;
            else
                next_q = next_q + 1'b1;
        end
    endfunction

    function automatic void resend_window();
        logic [SEQ_W:0] top;
        logic [SEQ_W:0] s;
        int             w;
        int             i;
        w   = usable_window();
        // The final packet stays in next_q once sent, so it counts as outstanding.
        top = final_sent_q ? {1'b0, next_q} + 1'b1 : {1'b0, next_q};
        s   = {1'b0, base_q};
        i   = 0;
        while (s < top && i < w && n_cmd < MAX_RESULTS) begin
            add_cmd(gbnsw_pkg::KIND_DATA, s[SEQ_W-1:0]);
            s++;
            i++;
        end
    endfunction

    function automatic void apply_event(input gbnsw_pkg::t_in_item ev);
        logic [SEQ_W:0] nb;
        int             i;
        n_cmd = 0;
        if (finished_q || ev.action == gbnsw_pkg::ACT_NONE)
            return;
        case (ev.action)
            gbnsw_pkg::ACT_START: begin
                retries_q = '0;
                send_fresh();
            end
            gbnsw_pkg::ACT_ACK: begin
                retries_q = '0;
                if (final_sent_q && ev.ack_seq >= next_q) begin
                    finished_q = 1'b1;
                    probing_q  = 1'b0;
                    base_q     = next_q;
                    add_cmd(gbnsw_pkg::KIND_DONE, '0);
                end else if (ev.peer_window == '0) begin
                    probing_q = 1'b1;
                    add_cmd(gbnsw_pkg::KIND_PROBE, '0);
                end else begin
                    probing_q = 1'b0;
                    peer_q    = ev.peer_window;
                    if (ev.ack_seq >= base_q) begin
                        nb     = {1'b0, ev.ack_seq} + 1'b1;
                        base_q = (nb < {1'b0, next_q}) ? nb[SEQ_W-1:0] : next_q;
                    end
                    send_fresh();
                end
            end
            default: begin
                if (retries_q != '1)
                    retries_q = retries_q + 1'b1;
                if (retries_q >= retry_limit_r) begin
                    finished_q = 1'b1;
                    add_cmd(gbnsw_pkg::KIND_ABORT, '0);
                end else if (probing_q) begin
                    add_cmd(gbnsw_pkg::KIND_PROBE, '0);
                end else begin
                    resend_window();
                end
            end
        endcase
        for (i = 0; i < n_cmd; i++) begin
            if (i == n_cmd - 1)
                cmd_buf[i].last = 1'b1;
            pending_cmds.push_back(cmd_buf[i]);
        end
    endfunction

    function automatic gbnsw_pkg::t_in_item make_event(input logic [1:0] action,
                                                       input int ack, input int pw);
        gbnsw_pkg::t_in_item ev;
        ev.action      = action;
        ev.ack_seq     = ack[SEQ_W-1:0];
        ev.peer_window = pw[SEQ_W-1:0];
        return ev;
    endfunction

    // Mostly well-formed traffic: acks inside the sent range, starts, and
    // timeouts kept below the retry limit, with some noise mixed in.
    function automatic gbnsw_pkg::t_in_item random_event();
        int r;
        int pw;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
            pw = 0;
        else if ($urandom_range(0, 9) < 7)
            pw = $urandom_range(1, WIN + 2);
        else
            pw = $urandom_range(1, 65535);
        if (r < 5)
            return make_event(gbnsw_pkg::ACT_NONE, $urandom_range(0, 65535),
                              $urandom_range(0, 65535));
        if (r < 12)
            return make_event(gbnsw_pkg::ACT_ACK, $urandom_range(0, 65535),
                              $urandom_range(0, 65535));
        if (r < 20)
            return make_event(gbnsw_pkg::ACT_START, $urandom_range(0, 65535),
                              $urandom_range(0, 65535));
        if (r < 36 && int'(retries_q) + 1 < int'(retry_limit_r))
            return make_event(gbnsw_pkg::ACT_TIMEOUT, $urandom_range(0, 65535),
                              $urandom_range(0, 65535));
        return make_event(gbnsw_pkg::ACT_ACK,
                          $urandom_range(int'(base_q) - 1, int'(next_q) - 1), pw);
    endfunction

    task automatic send_event(input gbnsw_pkg::t_in_item ev);
        int gap;
        gap = src_jitter ? $urandom_range(0, 8) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        evt_ch.valid <= 1'b1;
        evt_ch.data  <= ev;
        do @(posedge i_clk); while (!evt_ch.ready);
        apply_event(ev);
    endtask

    task automatic settle();
        @(negedge i_clk);
        evt_ch.valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == gbnsw_pkg::CFG_FINAL_SEQ)
            final_seq_r = value;
        else
            retry_limit_r = value[RETRY_W-1:0];
    endtask

    task automatic run_random(input int count);
        gbnsw_pkg::t_in_item ev;
        int                  done_cnt;
        done_cnt = 0;
        while (done_cnt < count) begin
            if (done_cnt % 25 == 0) begin
                src_jitter  = $urandom_range(0, 3) != 0;
                sink_jitter = $urandom_range(0, 3) != 0;
            end
            ev = random_event();
            send_event(ev);
            if (ev.action != gbnsw_pkg::ACT_NONE)
                done_cnt++;
        end
    endtask

    task automatic test_window_basics();
        src_jitter  = 1'b0;
        sink_jitter = 1'b0;
        write_reg(gbnsw_pkg::CFG_FINAL_SEQ, 16'hFFFF);
        write_reg(gbnsw_pkg::CFG_RETRY_LIMIT, 16'd255);
        send_event(make_event(gbnsw_pkg::ACT_NONE, 65535, 65535));
        // Nothing is outstanding yet, so this timeout yields no command.
        send_event(make_event(gbnsw_pkg::ACT_TIMEOUT, 0, 0));
        send_event(make_event(gbnsw_pkg::ACT_START, 0, 0));
        send_event(make_event(gbnsw_pkg::ACT_START, 0, 0));
        send_event(make_event(gbnsw_pkg::ACT_ACK, 0, 8));
        send_event(make_event(gbnsw_pkg::ACT_ACK, 3, 2));
        // An ack past everything sent pulls the base up to next_seq only.
        send_event(make_event(gbnsw_pkg::ACT_ACK, 65535, 65535));
        send_event(make_event(gbnsw_pkg::ACT_ACK, 10, 0));
        send_event(make_event(gbnsw_pkg::ACT_TIMEOUT, 0, 0));
        send_event(make_event(gbnsw_pkg::ACT_ACK, 12, 3));
        send_event(make_event(gbnsw_pkg::ACT_TIMEOUT, 0, 0));
        src_jitter  = 1'b1;
        sink_jitter = 1'b1;
        send_event(make_event(gbnsw_pkg::ACT_TIMEOUT, 0, 0));
        send_event(make_event(gbnsw_pkg::ACT_ACK, 16, 20));
        send_event(make_event(gbnsw_pkg::ACT_START, 0, 0));
        settle();
    endtask

    task automatic test_retry_count();
        write_reg(gbnsw_pkg::CFG_RETRY_LIMIT, 16'd3);
        send_event(make_event(gbnsw_pkg::ACT_TIMEOUT, 0, 0));
        send_event(make_event(gbnsw_pkg::ACT_TIMEOUT, 0, 0));
        send_event(make_event(gbnsw_pkg::ACT_ACK, int'(base_q) - 1, 5));
        send_event(make_event(gbnsw_pkg::ACT_TIMEOUT, 0, 0));
        send_event(make_event(gbnsw_pkg::ACT_TIMEOUT, 0, 0));
        send_event(make_event(gbnsw_pkg::ACT_START, 0, 0));
        send_event(make_event(gbnsw_pkg::ACT_TIMEOUT, 0, 0));
        settle();
    endtask

    task automatic test_random_traffic();
        write_reg(gbnsw_pkg::CFG_RETRY_LIMIT, 16'd255);
        run_random(70);
        settle();
        write_reg(gbnsw_pkg::CFG_FINAL_SEQ, 16'($urandom_range(30000, 65534)));
        write_reg(gbnsw_pkg::CFG_RETRY_LIMIT, 16'($urandom_range(3, 20)));
        run_random(60);
        settle();
    endtask

    // The result side stalls for a long stretch while events keep coming, so
    // the block fills up and holds off its input.
    task automatic test_backpressure();
        write_reg(gbnsw_pkg::CFG_RETRY_LIMIT, 16'd255);
        src_jitter  = 1'b0;
        sink_jitter = 1'b0;
        hold_cycles = 250;
        send_event(make_event(gbnsw_pkg::ACT_START, 0, 0));
        run_random(12);
        settle();
    endtask

    task automatic test_end_of_transfer();
        src_jitter  = 1'b1;
        sink_jitter = 1'b1;
        if ($urandom_range(0, 1))
            write_reg(gbnsw_pkg::CFG_FINAL_SEQ, 16'd1);
        else
            write_reg(gbnsw_pkg::CFG_FINAL_SEQ, next_q + 16'($urandom_range(0, 12)));
        write_reg(gbnsw_pkg::CFG_RETRY_LIMIT, 16'd255);
        send_event(make_event(gbnsw_pkg::ACT_START, 0, 0));
        while (!final_sent_q)
            send_event(make_event(gbnsw_pkg::ACT_ACK, int'(next_q) - 1,
                                  $urandom_range(1, 65535)));
        send_event(make_event(gbnsw_pkg::ACT_START, 0, 0));
        send_event(make_event(gbnsw_pkg::ACT_TIMEOUT, 0, 0));
        settle();
        write_reg(gbnsw_pkg::CFG_RETRY_LIMIT, 16'd1);
        if ($urandom_range(0, 1))
            send_event(make_event(gbnsw_pkg::ACT_ACK, int'(next_q) + $urandom_range(0, 3),
                                  $urandom_range(0, 65535)));
        else
            send_event(make_event(gbnsw_pkg::ACT_TIMEOUT, 0, 0));
        // The transfer is over: everything from here on must be dropped.
        send_event(make_event(gbnsw_pkg::ACT_START, 0, 0));
        send_event(make_event(gbnsw_pkg::ACT_TIMEOUT, 0, 0));
        send_event(make_event(gbnsw_pkg::ACT_ACK, 0, 8));
        settle();
    endtask

    initial begin : result_sink
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                res_ch.ready <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        gbnsw_pkg::t_out_item want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_cmds.size() == 0) begin
                $error("unexpected result: kind %0d seq %0d last %0d",
                       res_ch.data.kind, res_ch.data.seq, res_ch.data.last);
                errors++;
            end else begin
                want = pending_cmds.pop_front();
                if (res_ch.data.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, res_ch.data.kind);
                    errors++;
                end
                if (res_ch.data.seq !== want.seq) begin
                    $error("seq: expected %0d, got %0d", want.seq, res_ch.data.seq);
                    errors++;
                end
                if (res_ch.data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, res_ch.data.last);
                    errors++;
                end
            end
            sink_wait = sink_jitter ? $urandom_range(0, 8) : 0;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        evt_ch.valid  = 1'b0;
        evt_ch.data   = '0;
        errors        = 0;
        sink_wait     = 0;
        hold_cycles   = 0;
        src_jitter    = 1'b0;
        sink_jitter   = 1'b0;
        final_seq_r   = 16'd1;
        retry_limit_r = 8'd5;
        base_q        = 16'd1;
        next_q        = 16'd1;
        peer_q        = 16'(WIN);
        retries_q     = '0;
        probing_q     = 1'b0;
        final_sent_q  = 1'b0;
        finished_q    = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_window_basics();
        test_retry_count();
        test_random_traffic();
        test_backpressure();
        test_end_of_transfer();

        if (errors == 0 && pending_cmds.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/gbnsw_pkg.sv
rtl/core/gbnsw_chan_if.sv
rtl/core/gbnsw_ctrl.sv
rtl/core/gbnsw_datapath.sv
rtl/core/go_back_n_sender_window.sv
tb/sv/testbench.sv
